@@ sv/s256sd_pkg.sv @@
// Package for the SHA-256 seed derivation core: round constants, initial hash,
// padding words, rotate and byte-swap functions. No dependencies.
package s256sd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned ROUND_W = 6;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // Working variables a..h travel through the round cell as one struct
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_work;

    localparam t_word H0 = 32'h6a09e667;
    localparam t_word H1 = 32'hbb67ae85;
    localparam t_word H2 = 32'h3c6ef372;
    localparam t_word H3 = 32'ha54ff53a;
    localparam t_word H4 = 32'h510e527f;
    localparam t_word H5 = 32'h9b05688c;
    localparam t_word H6 = 32'h1f83d9ab;
    localparam t_word H7 = 32'h5be0cd19;

    localparam t_word PAD_MARK = 32'h80000000;
    localparam t_word PAD_LEN  = 32'd128;

    function automatic t_word round_k(input logic [ROUND_W-1:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word bswap(input t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

@@ sv/s256sd_if.sv @@
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload width set by parameter.
interface s256sd_if #(
    parameter int unsigned DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/s256sd_sched_cell.sv @@
// One cell of the 16-deep message schedule chain.
// Depends on s256sd_pkg.
module s256sd_sched_cell (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_shift,
    input  s256sd_pkg::t_word    i_load_word,
    input  s256sd_pkg::t_word    i_prev_word,
    output s256sd_pkg::t_word    o_word
);
    s256sd_pkg::t_word r_word;
    s256sd_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_load) begin
            n_word = i_load_word;
        end else if (i_shift) begin
            n_word = i_prev_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
endmodule

@@ sv/s256sd_round_cell.sv @@
// Compression round cell: holds a..h and applies one SHA-256 round per cycle while i_step is high.
// Depends on s256sd_pkg.
module s256sd_round_cell (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_step,
    input  s256sd_pkg::t_word    i_k,
    input  s256sd_pkg::t_word    i_w,
    output s256sd_pkg::t_work    o_work
);
    s256sd_pkg::t_work r_work;
    s256sd_pkg::t_work n_work;
    s256sd_pkg::t_word big0, big1, ch, maj, t1, t2;

    always_comb begin
        big1 = s256sd_pkg::rotr(r_work.e, 6) ^ s256sd_pkg::rotr(r_work.e, 11)
             ^ s256sd_pkg::rotr(r_work.e, 25);
        ch   = (r_work.e & r_work.f) ^ (~r_work.e & r_work.g);
        t1   = r_work.h + big1 + ch + i_k + i_w;
        big0 = s256sd_pkg::rotr(r_work.a, 2) ^ s256sd_pkg::rotr(r_work.a, 13)
             ^ s256sd_pkg::rotr(r_work.a, 22);
        maj  = (r_work.a & r_work.b) ^ (r_work.a & r_work.c) ^ (r_work.b & r_work.c);
        t2   = big0 + maj;
        n_work = r_work;
        if (i_load) begin
            n_work = '{s256sd_pkg::H0, s256sd_pkg::H1, s256sd_pkg::H2, s256sd_pkg::H3,
                       s256sd_pkg::H4, s256sd_pkg::H5, s256sd_pkg::H6, s256sd_pkg::H7};
        end else if (i_step) begin
            n_work.h = r_work.g;
            n_work.g = r_work.f;
            n_work.f = r_work.e;
            n_work.e = r_work.d + t1;
            n_work.d = r_work.c;
            n_work.c = r_work.b;
            n_work.b = r_work.a;
            n_work.a = t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_work = r_work;
endmodule

@@ sv/sha256_seed_derivation_core.sv @@
// Top level of the SHA-256 seed derivation core: control, schedule chain, round cell.
// Depends on s256sd_pkg, s256sd_if, s256sd_sched_cell, s256sd_round_cell.
//
//  channel  | dir | payload                                 | handshake
//  i_in     | in  | data[31:0]=tick_value, [95:32]=epoch    | valid/ready
//  o_out    | out | data[31:0]=seed_value                   | valid/ready
//
// The block loads at the accept edge, then the round cell runs 64 rounds, one per
// cycle, and the result is valid in ST_DONE once the last round is done.
// A new word is accepted in the cycle after the result is taken.
// Output stalls hold the working registers; reset is synchronous, active low.
module sha256_seed_derivation_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    s256sd_if.sink            i_in,
    s256sd_if.source          o_out
);
    localparam int unsigned NW = 16;

    s256sd_pkg::t_state r_state, n_state;
    logic [s256sd_pkg::ROUND_W-1:0] r_round;
    logic                            load, step, in_ready, out_valid;
    s256sd_pkg::t_word               w_tap [NW];
    s256sd_pkg::t_word               blk [NW];
    s256sd_pkg::t_word               w_new, s0, s1;
    s256sd_pkg::t_word               seed;
    s256sd_pkg::t_work               work;

    always_comb begin
        n_state = r_state;
        case (r_state)
            s256sd_pkg::ST_IDLE: if (i_in.valid) n_state = s256sd_pkg::ST_RUN;
            s256sd_pkg::ST_RUN:
                if (r_round == s256sd_pkg::ROUND_W'(s256sd_pkg::NUM_ROUNDS - 1))
                    n_state = s256sd_pkg::ST_DONE;
            s256sd_pkg::ST_DONE: if (o_out.ready) n_state = s256sd_pkg::ST_IDLE;
            default: n_state = s256sd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        step      = 1'b0;
        case (r_state)
            s256sd_pkg::ST_IDLE: in_ready  = 1'b1;
            s256sd_pkg::ST_RUN:  step      = 1'b1;
            s256sd_pkg::ST_DONE: out_valid = 1'b1;
            default: ;
        endcase
    end

    // the working registers hold still in ST_DONE, so the seed is stable there
    assign seed        = s256sd_pkg::bswap(s256sd_pkg::H0 + work.a);
    assign load        = in_ready & i_in.valid;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = seed;

    always_comb begin
        for (int i = 0; i < NW; i++) blk[i] = '0;
        blk[0]  = s256sd_pkg::bswap(i_in.data[31:0]);
        blk[2]  = s256sd_pkg::bswap(i_in.data[63:32]);
        blk[3]  = s256sd_pkg::bswap(i_in.data[95:64]);
        blk[4]  = s256sd_pkg::PAD_MARK;
        blk[15] = s256sd_pkg::PAD_LEN;
    end

    // tap 0 holds w[t]; the chain shifts toward 0, new word enters at the top
    assign s0 = s256sd_pkg::rotr(w_tap[1], 7) ^ s256sd_pkg::rotr(w_tap[1], 18)
              ^ (w_tap[1] >> 3);
    assign s1 = s256sd_pkg::rotr(w_tap[14], 17) ^ s256sd_pkg::rotr(w_tap[14], 19)
              ^ (w_tap[14] >> 10);
    assign w_new = w_tap[0] + s0 + w_tap[9] + s1;

    for (genvar g = 0; g < NW; g++) begin : g_sched
        s256sd_sched_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (load),
            .i_shift     (step),
            .i_load_word (blk[g]),
            .i_prev_word ((g == NW - 1) ? w_new : w_tap[(g + 1) % NW]),
            .o_word      (w_tap[g])
        );
    end

    s256sd_round_cell u_round (
        .i_clk  (i_clk),
        .i_load (load),
        .i_step (step),
        .i_k    (s256sd_pkg::round_k(r_round)),
        .i_w    (w_tap[0]),
        .o_work (work)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s256sd_pkg::ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_round <= '0;
            end else if (step) begin
                r_round <= r_round + 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_state == s256sd_pkg::ST_RUN && r_round == '0)
        else $error("load did not start rounds");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("accept while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(o_out.data))
        else $error("seed changed under stall");
endmodule
